// ===== hdl/mips_subset_single_cycle_core_defines.svh =====
// Assertion macros used by the port checker of the core.
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_DEFINES_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_DEFINES_SVH

// Property checked on every rising clock edge, reset included.
`define MSSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Property checked on rising clock edges outside reset.
`define MSSC_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== hdl/mssc_pkg.sv =====
// Shared types and constants of the MIPS subset core.
package mssc_pkg;

  localparam int unsigned DMEM_BYTES_DEF = 4096;
  localparam int unsigned DMEM_LANES = 4;
  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned REG_AW = 5;

  localparam logic [1:0] CMD_EXEC       = 2'd0;
  localparam logic [1:0] CMD_WRITE_BYTE = 2'd1;
  localparam logic [1:0] CMD_READ_BYTE  = 2'd2;
  localparam logic [1:0] CMD_READ_REG   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] instruction;
    logic [15:0] byte_address;
    logic [7:0]  byte_value;
    logic [4:0]  reg_index;
  } item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        wb_enable;
    logic [4:0]  wb_reg;
    logic [31:0] wb_value;
    logic [31:0] read_value;
    logic        addr_fault;
  } result_t;

  // Work done by the execute stage, waiting for the data memory read.
  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        wb_enable;
    logic [4:0]  wb_reg;
    logic [31:0] wb_value;
    logic [31:0] read_value;
    logic        addr_fault;
    logic        load;
    logic        byte_read;
    logic [1:0]  lane;
  } exec_t;

  // Data memory access request; word accesses are big-endian.
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic        word;
    logic [15:0] addr;
    logic [31:0] wdata;
  } mem_req_t;

  // Pending register write-back seen by the execute stage.
  typedef struct packed {
    logic        valid;
    logic [4:0]  idx;
    logic [31:0] value;
  } fwd_t;

endpackage

// ===== hdl/mssc_regfile.sv =====
// Register file with two registered read ports, one write port and per-entry valid bits.
module mssc_regfile (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [mssc_pkg::REG_AW-1:0] ra_addr,
  input  logic [mssc_pkg::REG_AW-1:0] rb_addr,
  output logic [31:0]                 ra_data,
  output logic [31:0]                 rb_data,
  input  logic                        we,
  input  logic [mssc_pkg::REG_AW-1:0] wa_addr,
  input  logic [31:0]                 wa_data
);
  import mssc_pkg::*;

  logic [31:0]         regs [NUM_REGS];
  logic [NUM_REGS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wa_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      regs[wa_addr] <= wa_data;
    end
  end

  // A write in the same cycle is passed straight to the read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (we && wa_addr == ra_addr) begin
        ra_data <= wa_data;
      end else begin
        ra_data <= vld[ra_addr] ? regs[ra_addr] : 32'd0;
      end
      if (we && wa_addr == rb_addr) begin
        rb_data <= wa_data;
      end else begin
        rb_data <= vld[rb_addr] ? regs[rb_addr] : 32'd0;
      end
    end
  end

endmodule

// ===== hdl/mssc_dmem_bank.sv =====
// One byte lane of the four-way interleaved data memory.
module mssc_dmem_bank #(
  parameter  int unsigned DMEM_BYTES = mssc_pkg::DMEM_BYTES_DEF,
  parameter  int unsigned LANE       = 0,
  localparam int unsigned ROWS       = (DMEM_BYTES + 3) / 4,
  localparam int unsigned RW         = $clog2(ROWS)
) (
  input  logic               clk,
  input  logic               clr,
  input  logic [RW-1:0]      clr_row,
  input  logic               en,
  input  mssc_pkg::mem_req_t req,
  output logic [7:0]         rdata
);
  import mssc_pkg::*;

  logic [7:0]  mem [ROWS];
  logic [1:0]  lane_id;
  logic [1:0]  k;
  logic [13:0] row_full;
  logic [RW-1:0] row;
  logic        hit;
  logic [7:0]  wbyte;

  assign lane_id = 2'(LANE);

  always_comb begin
    // k is the byte's place in the big-endian word.
    k = lane_id - req.addr[1:0];
    if (req.word) begin
      hit      = 1'b1;
      row_full = req.addr[15:2] + 14'(lane_id < req.addr[1:0]);
      unique case (k)
        2'd0:    wbyte = req.wdata[31:24];
        2'd1:    wbyte = req.wdata[23:16];
        2'd2:    wbyte = req.wdata[15:8];
        default: wbyte = req.wdata[7:0];
      endcase
    end else begin
      hit      = (req.addr[1:0] == lane_id);
      row_full = req.addr[15:2];
      wbyte    = req.wdata[7:0];
    end
    row = row_full[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      mem[clr_row] <= 8'd0;
    end else if (en && req.wr && hit) begin
      mem[row] <= wbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (en && req.rd) begin
      rdata <= mem[row];
    end
  end

endmodule

// ===== hdl/mssc_execute.sv =====
// Decode, operand forwarding, ALU, branch and address logic of the execute stage.
module mssc_execute #(
  parameter int unsigned DMEM_BYTES = mssc_pkg::DMEM_BYTES_DEF
) (
  input  mssc_pkg::item_t    item,
  input  logic [31:0]        ra_data,
  input  logic [31:0]        rb_data,
  input  mssc_pkg::fwd_t     fwd,
  input  logic [31:0]        pc,
  input  logic               halted,
  output mssc_pkg::exec_t    ex,
  output mssc_pkg::mem_req_t req
);
  import mssc_pkg::*;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  localparam logic [2:0] ALU_ADDU = 3'd1;
  localparam logic [2:0] ALU_SUBU = 3'd3;
  localparam logic [2:0] ALU_AND  = 3'd4;
  localparam logic [2:0] ALU_OR   = 3'd5;
  localparam logic [2:0] ALU_NOR  = 3'd7;

  function automatic logic [31:0] alu(input logic [2:0] sel, input logic [31:0] x,
                                      input logic [31:0] y);
    logic [31:0] r;
    unique case (sel)
      ALU_ADDU: r = x + y;
      ALU_SUBU: r = x - y;
      ALU_AND:  r = x & y;
      ALU_OR:   r = x | y;
      ALU_NOR:  r = ~(x | y);
      default:  r = y;
    endcase
    return r;
  endfunction

  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  ra_idx;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] simm;
  logic [31:0] pc4;
  logic [31:0] addr;
  logic        word_ok;
  logic        byte_ok;
  logic        wb;
  logic [4:0]  wreg;
  logic [31:0] wval;

  assign op     = item.instruction[31:26];
  assign rs     = item.instruction[25:21];
  assign rt     = item.instruction[20:16];
  assign rd     = item.instruction[15:11];
  assign ra_idx = (item.cmd == CMD_READ_REG) ? item.reg_index : rs;

  // The newer write-back still in flight wins over the register file data.
  assign a = (fwd.valid && fwd.idx == ra_idx) ? fwd.value : ra_data;
  assign b = (fwd.valid && fwd.idx == rt) ? fwd.value : rb_data;

  assign simm    = {{16{item.instruction[15]}}, item.instruction[15:0]};
  assign pc4     = pc + 32'd4;
  assign addr    = a + simm;
  assign word_ok = addr < 32'(DMEM_BYTES - 3);
  assign byte_ok = {1'b0, item.byte_address} < 17'(DMEM_BYTES);

  always_comb begin
    ex         = '0;
    ex.next_pc = pc;
    ex.halted  = halted;
    req        = '0;
    wb         = 1'b0;
    wreg       = '0;
    wval       = '0;
    unique case (item.cmd)
      CMD_WRITE_BYTE: begin
        if (byte_ok) begin
          req.wr    = 1'b1;
          req.addr  = item.byte_address;
          req.wdata = {24'd0, item.byte_value};
        end else begin
          ex.addr_fault = 1'b1;
        end
      end
      CMD_READ_BYTE: begin
        if (byte_ok) begin
          req.rd       = 1'b1;
          req.addr     = item.byte_address;
          ex.byte_read = 1'b1;
          ex.lane      = item.byte_address[1:0];
        end else begin
          ex.addr_fault = 1'b1;
        end
      end
      CMD_READ_REG: begin
        ex.read_value = a;
      end
      default: begin
        if (!halted) begin
          ex.next_pc = pc4;
          if (item.instruction == '1) begin
            ex.halted = 1'b1;
          end else begin
            unique case (op)
              OP_J: begin
                ex.next_pc = {pc4[31:28], item.instruction[25:0], 2'b00};
              end
              OP_BEQ: begin
                if (a == b) begin
                  ex.next_pc = pc4 + {simm[29:0], 2'b00};
                end
              end
              OP_LW: begin
                if (!word_ok) begin
                  ex.addr_fault = 1'b1;
                end else begin
                  req.rd   = 1'b1;
                  req.word = 1'b1;
                  req.addr = addr[15:0];
                  ex.load  = 1'b1;
                  ex.lane  = addr[1:0];
                  wb       = 1'b1;
                  wreg     = rt;
                end
              end
              OP_SW: begin
                if (!word_ok) begin
                  ex.addr_fault = 1'b1;
                end else begin
                  req.wr    = 1'b1;
                  req.word  = 1'b1;
                  req.addr  = addr[15:0];
                  req.wdata = b;
                end
              end
              OP_RTYPE: begin
                wb   = 1'b1;
                wreg = rd;
                wval = alu(item.instruction[2:0], a, b);
              end
              default: begin
                wb   = 1'b1;
                wreg = rt;
                wval = alu(op[2:0], a, simm);
              end
            endcase
          end
        end
      end
    endcase
    // Register 0 is never written; the load value joins one stage later.
    if (wb && wreg != 5'd0) begin
      ex.wb_enable = 1'b1;
      ex.wb_reg    = wreg;
      ex.wb_value  = wval;
    end else begin
      ex.load = 1'b0;
    end
  end

endmodule

// ===== hdl/mips_subset_single_cycle_core.sv =====
// Top level of the MIPS subset core: pipeline registers, pc, halt flag and memory clearing.
//
//   channel  | direction | handshake                   | word
//   ---------+-----------+-----------------------------+-------------------
//   item     | in        | item_valid / item_stall     | mssc_pkg::item_t
//   result   | out       | result_valid / result_stall | mssc_pkg::result_t
//
// The core takes one word per clock cycle while item_stall is low. On its way to the
// result, the item and its register operands are registered as it is taken, execute
// runs and issues the data memory access as the item moves into stage 2, and the loaded
// data joins the rest of the word in the result register. The throughput figure is set
// by the forwarding path from the memory stage back into execute and by the four byte
// banks, each with one read and one write port, which serve any word access.
// After reset the data memory is cleared one row of four bytes per cycle; item_stall is
// high until the last row has been cleared.
// A stalled result backs the pipeline up stage by stage; item_stall rises during the
// memory clear and when the first stage is full and cannot move on.
module mips_subset_single_cycle_core #(
  parameter int unsigned DMEM_BYTES = mssc_pkg::DMEM_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  mssc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output mssc_pkg::result_t result
);
  import mssc_pkg::*;

  localparam int unsigned ROWS = (DMEM_BYTES + 3) / 4;
  localparam int unsigned RW   = $clog2(ROWS);

  // Architectural state that is not held in a memory.
  logic [31:0] pc;
  logic        halt;

  // Clearing pass over the data memory banks.
  logic          clr_busy;
  logic [RW-1:0] clr_row;

  // Stage 1 holds the accepted item and its register operands.
  logic        s1_valid;
  item_t       s1;
  logic [31:0] ra_data;
  logic [31:0] rb_data;

  // Stage 2 holds the executed item while the data memory read completes.
  logic        s2_valid;
  exec_t       s2;

  exec_t       ex;
  mem_req_t    req;
  fwd_t        fwd;
  result_t     s2_res;
  logic [7:0]  bank_rdata [DMEM_LANES];
  logic [31:0] load_word;

  logic accept;
  logic out_free;
  logic s2_adv;
  logic s2_free;
  logic s1_adv;

  // Flow control: each stage moves when the one after it is empty or moving.
  assign out_free   = !result_valid || !result_stall;
  assign s2_adv     = s2_valid && out_free;
  assign s2_free    = !s2_valid || s2_adv;
  assign s1_adv     = s1_valid && s2_free;
  assign item_stall = clr_busy || (s1_valid && !s2_free);
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_row  <= '0;
    end else if (clr_busy) begin
      if (clr_row == RW'(ROWS - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_row <= clr_row + RW'(1);
    end
  end

  // Register reads are issued straight from the incoming word. Port A serves the
  // register read command as well as rs.
  mssc_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .ra_addr ((item.cmd == CMD_READ_REG) ? item.reg_index : item.instruction[25:21]),
    .rb_addr (item.instruction[20:16]),
    .ra_data (ra_data),
    .rb_data (rb_data),
    .we      (s2_adv && s2_res.wb_enable),
    .wa_addr (s2_res.wb_reg),
    .wa_data (s2_res.wb_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= item;
    end
  end

  // The item in stage 2 has not yet written the register file, so its write-back
  // value, a loaded word included, is forwarded into execute.
  assign fwd.valid = s2_valid && s2.wb_enable;
  assign fwd.idx   = s2.wb_reg;
  assign fwd.value = s2_res.wb_value;

  mssc_execute #(
    .DMEM_BYTES (DMEM_BYTES)
  ) u_execute (
    .item    (s1),
    .ra_data (ra_data),
    .rb_data (rb_data),
    .fwd     (fwd),
    .pc      (pc),
    .halted  (halt),
    .ex      (ex),
    .req     (req)
  );

  // The pc and halt flag change as the item leaves execute, so the next item sees them.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= 32'd0;
      halt <= 1'b0;
    end else if (s1_adv) begin
      pc   <= ex.next_pc;
      halt <= ex.halted;
    end
  end

  // Four byte banks, interleaved by the low address bits: the four bytes of any word,
  // aligned or not, fall in four different banks.
  for (genvar j = 0; j < DMEM_LANES; j++) begin : g_bank
    mssc_dmem_bank #(
      .DMEM_BYTES (DMEM_BYTES),
      .LANE       (j)
    ) u_bank (
      .clk     (clk),
      .clr     (clr_busy),
      .clr_row (clr_row),
      .en      (s1_adv),
      .req     (req),
      .rdata   (bank_rdata[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2 <= ex;
    end
  end

  // Big-endian word assembly: byte k of the word sits in bank (lane + k) mod 4.
  always_comb begin
    for (int k = 0; k < DMEM_LANES; k++) begin
      load_word[31 - 8*k -: 8] = bank_rdata[2'(s2.lane + 2'(k))];
    end
  end

  always_comb begin
    s2_res.next_pc    = s2.next_pc;
    s2_res.halted     = s2.halted;
    s2_res.wb_enable  = s2.wb_enable;
    s2_res.wb_reg     = s2.wb_reg;
    s2_res.wb_value   = s2.load ? load_word : s2.wb_value;
    s2_res.read_value = s2.byte_read ? {24'd0, bank_rdata[s2.lane]} : s2.read_value;
    s2_res.addr_fault = s2.addr_fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_adv) begin
      result_valid <= 1'b1;
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      result <= s2_res;
    end
  end

endmodule

// ===== hdl/mssc_checker.sv =====
// Port-level checker for the core and its bind to the top level.
`include "mips_subset_single_cycle_core_defines.svh"

module mssc_port_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input mssc_pkg::result_t result
);
  import mssc_pkg::*;

  // Set once a halted result word has been delivered.
  logic seen_halt;
  // High when both write-back fields of the result word are zero.
  logic wb_fields_clear;

  assign wb_fields_clear = (result.wb_reg == 5'd0) && (result.wb_value == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
    end else if (result_valid && !result_stall && result.halted) begin
      seen_halt <= 1'b1;
    end
  end

  `MSSC_ASSERT_ALWAYS(a_reset_empties, rst |=> !result_valid, "result valid after reset")
  `MSSC_ASSERT_ALWAYS(a_clear_blocks, $fell(rst) |-> item_stall, "item taken during clear")
  `MSSC_ASSERT_RUN(a_wb_quiet, result_valid && !result.wb_enable |-> wb_fields_clear, "stray write-back")
  `MSSC_ASSERT_RUN(a_halt_sticky, result_valid && seen_halt |-> result.halted, "halt flag dropped")

endmodule

bind mips_subset_single_cycle_core mssc_port_checker u_checker (.*);

// ===== tb/mssc_checker.sv =====
`timescale 1ns / 1ps
// Instruction encodings and the checker that predicts and compares the core's result words.

package mssc_isa_pkg;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  localparam logic [2:0] ALU_ADDU = 3'd1;
  localparam logic [2:0] ALU_SUBU = 3'd3;
  localparam logic [2:0] ALU_AND  = 3'd4;
  localparam logic [2:0] ALU_OR   = 3'd5;
  localparam logic [2:0] ALU_NOR  = 3'd7;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;

  localparam logic [31:0] HALT_WORD = 32'hffff_ffff;

endpackage

module mssc_checker #(
  parameter int unsigned DMEM_BYTES = mssc_pkg::DMEM_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  mssc_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  mssc_pkg::result_t result,
  output int                errors,
  output int                pending,
  output int                checked
);
  import mssc_pkg::*;
  import mssc_isa_pkg::*;

  logic [31:0] pc_model;
  logic        halt_model;
  logic [31:0] regs [NUM_REGS];
  logic [7:0]  dmem [DMEM_BYTES];
  result_t     expected_q [$];
  int          failures;
  int          seen;

  function automatic logic [31:0] alu_result(logic [2:0] sel, logic [31:0] a, logic [31:0] b);
    case (sel)
      ALU_ADDU: return a + b;
      ALU_SUBU: return a - b;
      ALU_AND:  return a & b;
      ALU_OR:   return a | b;
      ALU_NOR:  return ~(a | b);
      default:  return b;
    endcase
  endfunction

  // Applies one command word to the local copy of the core state and returns the result word.
  function automatic result_t execute_word(item_t w);
    result_t     r;
    logic [31:0] pc4, simm, a, b, npc, addr, wval;
    logic [5:0]  op;
    logic [4:0]  wreg;
    logic        wb;
    r    = '0;
    wb   = 1'b0;
    wreg = '0;
    wval = '0;
    op   = w.instruction[31:26];
    a    = regs[w.instruction[25:21]];
    b    = regs[w.instruction[20:16]];
    simm = {{16{w.instruction[15]}}, w.instruction[15:0]};
    pc4  = pc_model + 32'd4;
    npc  = pc4;
    addr = a + simm;
    case (w.cmd)
      CMD_WRITE_BYTE: begin
        if (w.byte_address < DMEM_BYTES) dmem[w.byte_address] = w.byte_value;
        else r.addr_fault = 1'b1;
      end
      CMD_READ_BYTE: begin
        if (w.byte_address < DMEM_BYTES) r.read_value = {24'd0, dmem[w.byte_address]};
        else r.addr_fault = 1'b1;
      end
      CMD_READ_REG: begin
        r.read_value = regs[w.reg_index];
      end
      CMD_EXEC: begin
        if (!halt_model) begin
          if (w.instruction == HALT_WORD) begin
            halt_model = 1'b1;
          end else if (op == OP_J) begin
            npc = {pc4[31:28], w.instruction[25:0], 2'b00};
          end else if (op == OP_BEQ) begin
            if (a == b) npc = pc4 + {simm[29:0], 2'b00};
          end else if (op == OP_LW || op == OP_SW) begin
            if ({1'b0, addr} + 33'd3 >= DMEM_BYTES) begin
              r.addr_fault = 1'b1;
            end else if (op == OP_LW) begin
              wb   = 1'b1;
              wreg = w.instruction[20:16];
              wval = {dmem[addr], dmem[addr + 32'd1], dmem[addr + 32'd2], dmem[addr + 32'd3]};
            end else begin
              dmem[addr]         = b[31:24];
              dmem[addr + 32'd1] = b[23:16];
              dmem[addr + 32'd2] = b[15:8];
              dmem[addr + 32'd3] = b[7:0];
            end
          end else if (op == OP_RTYPE) begin
            wb   = 1'b1;
            wreg = w.instruction[15:11];
            wval = alu_result(w.instruction[2:0], a, b);
          end else begin
            wb   = 1'b1;
            wreg = w.instruction[20:16];
            wval = alu_result(op[2:0], a, simm);
          end
          // Register 0 never changes, and a dropped write reports nothing.
          if (wb && wreg != '0) begin
            regs[wreg] = wval;
          end else begin
            wb   = 1'b0;
            wreg = '0;
            wval = '0;
          end
          pc_model = npc;
        end
      end
    endcase
    r.next_pc   = pc_model;
    r.halted    = halt_model;
    r.wb_enable = wb;
    r.wb_reg    = wreg;
    r.wb_value  = wval;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pc_model   = '0;
      halt_model = 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
      for (int i = 0; i < DMEM_BYTES; i++) dmem[i] = '0;
      expected_q.delete();
      failures = 0;
      seen     = 0;
    end else begin
      if (item_valid && !item_stall) expected_q.push_back(execute_word(item));
      if (result_valid && !result_stall) begin
        seen++;
        if (expected_q.size() == 0) begin
          if (failures < 10) $display("ERROR: result word %h arrived with none expected at %0t",
                                      result, $time);
          failures++;
        end else begin
          want = expected_q.pop_front();
          if (result.next_pc !== want.next_pc || result.halted !== want.halted ||
              result.wb_enable !== want.wb_enable || result.wb_reg !== want.wb_reg ||
              result.wb_value !== want.wb_value || result.read_value !== want.read_value ||
              result.addr_fault !== want.addr_fault) begin
            if (failures < 10) begin
              $display("ERROR: result word %0d differs at %0t", seen, $time);
              $display("  expected pc=%h halted=%b wb=%b reg=%0d value=%h read=%h fault=%b",
                       want.next_pc, want.halted, want.wb_enable, want.wb_reg,
                       want.wb_value, want.read_value, want.addr_fault);
              $display("  actual   pc=%h halted=%b wb=%b reg=%0d value=%h read=%h fault=%b",
                       result.next_pc, result.halted, result.wb_enable, result.wb_reg,
                       result.wb_value, result.read_value, result.addr_fault);
            end
            failures++;
          end
        end
      end
    end
    errors  <= failures;
    pending <= expected_q.size();
    checked <= seen;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the MIPS subset core: clock, reset, command stimulus and the verdict.
module tb_top;
  import mssc_pkg::*;
  import mssc_isa_pkg::*;

  localparam int unsigned DMEM = mssc_pkg::DMEM_BYTES_DEF;
  localparam int RANDOM_WORDS  = 800;
  localparam int TAIL_WORDS    = 20;
  // The limit is several times the slowest run: the memory clear plus every word meeting
  // the longest sender gap and the longest result stall.
  localparam int CYCLE_LIMIT   = 600000;
  // The core answers each word through its stage registers, so this leaves ample room.
  localparam int SETTLE_CYCLES = 12;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int   errors;
  int   pending;
  int   checked;
  int   cycles    = 0;
  int   stall_run = 0;
  logic quiet     = 1'b0;
  int   sent [4]  = '{0, 0, 0, 0};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mips_subset_single_cycle_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  mssc_checker #(.DMEM_BYTES(DMEM)) u_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked)
  );

  // The cycle counter is the watchdog. At the end of each stretch it also decides whether
  // the next stretch runs quiet, with no sender gaps and no result stalls at all, so
  // that back-to-back traffic is exercised as well as the idling patterns.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 300 == 299) quiet <= ($urandom_range(0, 3) == 0);
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d result words still expected", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The result side stalls in bursts of random length, now and then a long stretch that
  // backs the whole pipeline up into item_stall.
  always @(posedge clk) begin
    int pick;
    if (rst || quiet) begin
      stall_run = 0;
      result_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      result_stall <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 20) stall_run = $urandom_range(1, 3);
      else if (pick < 23) stall_run = $urandom_range(15, 60);
      result_stall <= 1'b0;
    end
  end

  // Gap in cycles before the sender raises valid for the next word.
  function automatic int pick_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Every field is random, so that the fields a command ignores still toggle all bits.
  function automatic item_t noise_item();
    item_t w;
    w.cmd          = 2'($urandom);
    w.instruction  = $urandom;
    w.byte_address = 16'($urandom);
    w.byte_value   = 8'($urandom);
    w.reg_index    = 5'($urandom);
    return w;
  endfunction

  function automatic item_t exec_item(logic [31:0] instr);
    item_t w;
    w             = noise_item();
    w.cmd         = CMD_EXEC;
    w.instruction = instr;
    return w;
  endfunction

  function automatic item_t write_byte_item(logic [15:0] addr, logic [7:0] value);
    item_t w;
    w              = noise_item();
    w.cmd          = CMD_WRITE_BYTE;
    w.byte_address = addr;
    w.byte_value   = value;
    return w;
  endfunction

  function automatic item_t read_byte_item(logic [15:0] addr);
    item_t w;
    w              = noise_item();
    w.cmd          = CMD_READ_BYTE;
    w.byte_address = addr;
    return w;
  endfunction

  function automatic item_t read_reg_item(logic [4:0] idx);
    item_t w;
    w           = noise_item();
    w.cmd       = CMD_READ_REG;
    w.reg_index = idx;
    return w;
  endfunction

  // R-type word; the shift amount field is unused by the core and left random.
  function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [5:0] funct);
    return {OP_RTYPE, rs, rt, rd, 5'($urandom), funct};
  endfunction

  function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Byte addresses land mostly inside the data memory and sometimes anywhere in 16 bits.
  function automatic logic [15:0] pick_byte_addr();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, DMEM - 1));
  endfunction

  // One random command word. Most words are well-formed instructions whose addresses hit
  // the data memory, so loads see earlier stores and byte writes; some are pure noise.
  // The halt word is kept out here because a halted core ignores every later instruction.
  function automatic item_t random_word();
    item_t       w;
    int          p;
    int          k;
    logic [4:0]  rs, rt;
    logic [5:0]  op, fn;
    logic [15:0] imm;
    w  = noise_item();
    rs = 5'($urandom);
    rt = 5'($urandom);
    p  = $urandom_range(0, 99);
    if (p < 8) begin
      // Keep the noise word as it is.
    end else if (p < 18) begin
      w = write_byte_item(pick_byte_addr(), 8'($urandom));
    end else if (p < 28) begin
      w = read_byte_item(pick_byte_addr());
    end else if (p < 36) begin
      w = read_reg_item(5'($urandom));
    end else begin
      k = $urandom_range(0, 9);
      case (k)
        0, 1, 2: begin
          case ($urandom_range(0, 5))
            0:       fn = FN_ADDU;
            1:       fn = FN_SUBU;
            2:       fn = FN_AND;
            3:       fn = FN_OR;
            4:       fn = FN_NOR;
            default: fn = 6'($urandom);
          endcase
          w = exec_item(r_word(rs, rt, 5'($urandom), fn));
        end
        3, 4: begin
          op = ($urandom_range(0, 1) == 0) ? OP_ADDIU : 6'($urandom);
          if (op == OP_RTYPE || op == OP_J || op == OP_BEQ || op == OP_LW || op == OP_SW)
            op = OP_ADDIU;
          w = exec_item(i_word(op, rs, rt, 16'($urandom)));
        end
        5, 6: begin
          // Mostly absolute addresses off register 0, the rest near a register's value.
          if ($urandom_range(0, 3) != 0) begin
            rs  = '0;
            imm = 16'($urandom_range(0, DMEM - 1));
          end else begin
            imm = 16'($urandom_range(0, 31)) - 16'd16;
          end
          w = exec_item(i_word((k == 5) ? OP_LW : OP_SW, rs, rt, imm));
        end
        7: begin
          if ($urandom_range(0, 1) == 0) rt = rs;
          w = exec_item(i_word(OP_BEQ, rs, rt, 16'($urandom)));
        end
        8: begin
          w = exec_item({OP_J, 26'($urandom)});
        end
        default: begin
          // Small values make registers usable as base addresses.
          w = exec_item(i_word(OP_ADDIU, 5'd0, rt, 16'($urandom_range(0, DMEM - 4))));
        end
      endcase
    end
    if (w.cmd == CMD_EXEC && w.instruction == HALT_WORD) w.instruction[0] = 1'b0;
    return w;
  endfunction

  // Offers one word and returns at the edge where the core takes it. The payload holds
  // still while item_stall is high; valid stays up when the next word follows directly.
  task automatic send_word(input item_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sent[w.cmd]++;
  endtask

  // Holds the sender back until every expected result word has come out.
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Byte commands at the edges of the data memory and beyond it, while
    // item_stall still covers the memory clear after reset.
    send_word(read_reg_item(5'd0));
    send_word(read_byte_item(16'h0100));
    send_word(write_byte_item(16'h0000, 8'hff));
    send_word(write_byte_item(16'(DMEM - 1), 8'h80));
    send_word(write_byte_item(16'hffff, 8'h5a));
    send_word(read_byte_item(16'(DMEM - 1)));
    send_word(read_byte_item(16'(DMEM)));
    // The largest positive and the most negative immediate, then each ALU operation.
    send_word(exec_item(i_word(OP_ADDIU, 5'd0, 5'd1, 16'h7fff)));
    send_word(exec_item(i_word(OP_ADDIU, 5'd0, 5'd2, 16'h8000)));
    send_word(exec_item(r_word(5'd1, 5'd2, 5'd3, FN_ADDU)));
    send_word(exec_item(r_word(5'd1, 5'd2, 5'd4, FN_SUBU)));
    send_word(exec_item(r_word(5'd1, 5'd2, 5'd5, FN_AND)));
    send_word(exec_item(r_word(5'd1, 5'd2, 5'd6, FN_OR)));
    send_word(exec_item(r_word(5'd1, 5'd2, 5'd7, FN_NOR)));
    // An unlisted function code and an unlisted immediate opcode pass the second operand.
    send_word(exec_item(r_word(5'd1, 5'd2, 5'd8, FN_SLL)));
    send_word(exec_item(i_word(OP_ADDI, 5'd1, 5'd9, 16'h1234)));
    // A write to register 0 is dropped.
    send_word(exec_item(i_word(OP_ADDIU, 5'd1, 5'd0, 16'h0005)));
    // Store, then an unaligned load over it, a load just past the top of memory, a load
    // of the last whole word, and a store through a negative base that wraps high.
    send_word(exec_item(i_word(OP_SW, 5'd0, 5'd4, 16'h0008)));
    send_word(exec_item(i_word(OP_LW, 5'd0, 5'd10, 16'h0007)));
    send_word(exec_item(i_word(OP_LW, 5'd0, 5'd11, 16'(DMEM - 3))));
    send_word(exec_item(i_word(OP_LW, 5'd0, 5'd12, 16'(DMEM - 4))));
    send_word(exec_item(i_word(OP_SW, 5'd2, 5'd1, 16'h0000)));
    // Branch not taken, branch taken backwards, and a jump to the highest target.
    send_word(exec_item(i_word(OP_BEQ, 5'd1, 5'd2, 16'h0005)));
    send_word(exec_item(i_word(OP_BEQ, 5'd3, 5'd3, 16'hffff)));
    send_word(exec_item({OP_J, 26'h3ff_ffff}));
    wait_drained();

    // Random part, with a full drain every couple of hundred words.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      send_word(random_word());
      if (i % 200 == 199) wait_drained();
    end

    // Halting is permanent, so it closes the run: the halt word, then instructions the
    // halted core must ignore mixed with byte commands and register reads that still work.
    send_word(exec_item(HALT_WORD));
    for (int i = 0; i < TAIL_WORDS; i++) send_word(random_word());

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d command words: %0d executes, %0d byte writes,",
             sent[CMD_EXEC] + sent[CMD_WRITE_BYTE] + sent[CMD_READ_BYTE] + sent[CMD_READ_REG],
             sent[CMD_EXEC], sent[CMD_WRITE_BYTE]);
    $display("%0d byte reads and %0d register reads; %0d result words compared, halted at end",
             sent[CMD_READ_BYTE], sent[CMD_READ_REG], checked);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
